[rtl/sdn_pkg.sv]
package sdn_pkg;

    localparam int MAG_W     = 32;
    localparam int POS_W     = 8;
    localparam int PIX_W     = 8;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 2;

    // long division of 255*v by the peak: quotient bits, dividend width
    localparam int QUOT_W = 8;
    localparam int NUM_W  = MAG_W + QUOT_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ENABLE  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quotient;
        logic [MAG_W-1:0]    remainder;
    } div_result_t;

endpackage

[rtl/spectrum_display_normalizer.sv]
// load transaction: an in-frame load is written to the frame store and the peak at the accept edge;
// loads never stall the input. read transaction: the input stalls until the result is loaded into the
// output register; out of frame it goes straight to write, a pixel that is 0 or saturated goes fetch
// then write, any other goes fetch, the bit-serial divider, then write; a stalled output adds its wait
// reset: peak cleared, frame size 256x256, grid off; the frame store holds garbage until loaded
module spectrum_display_normalizer
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int GRID_SPACING = 100
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_write,
    input  logic [sdn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdn_pkg::SIZE_W-1:0]      cfg_data,

    // input transaction channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [sdn_pkg::POS_W-1:0]       pos_x,
    input  logic [sdn_pkg::POS_W-1:0]       pos_y,
    input  logic [sdn_pkg::MAG_W-1:0]       magnitude,

    // output transaction channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sdn_pkg::PIX_W-1:0]       pixel
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // effective frame size: even, clamped to 2..max
    function automatic logic [sdn_pkg::SIZE_W-1:0] eff_size(
        input logic [sdn_pkg::SIZE_W-1:0] r,
        input int                         max_size
    );
        logic [sdn_pkg::SIZE_W-1:0] s;
        s = {r[sdn_pkg::SIZE_W-1:1], 1'b0};
        if (s < sdn_pkg::SIZE_W'(2))
        begin
            s = sdn_pkg::SIZE_W'(2);
        end
        if (int'(s) > max_size)
        begin
            s = sdn_pkg::SIZE_W'(max_size & ~1);
        end
        return s;
    endfunction

    // remainder by the grid spacing: restoring steps against shifted constants
    function automatic logic [sdn_pkg::POS_W-1:0] grid_mod(
        input logic [sdn_pkg::POS_W-1:0] val
    );
        logic [sdn_pkg::POS_W-1:0] r;
        r = val;
        for (int k = sdn_pkg::POS_W - 1; k >= 0; k--)
        begin
            if (int'(r) >= (GRID_SPACING << k))
            begin
                r = r - sdn_pkg::POS_W'(GRID_SPACING << k);
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] store_addr(
        input logic [sdn_pkg::SIZE_W-1:0] col,
        input logic [sdn_pkg::SIZE_W-1:0] row
    );
        return AW'(int'(row) * MAX_WIDTH + int'(col));
    endfunction

    // configuration registers
    logic [sdn_pkg::SIZE_W-1:0]   frame_width_reg;
    logic [sdn_pkg::SIZE_W-1:0]   frame_height_reg;
    logic                         grid_enable_reg;

    // control and datapath state
    sdn_pkg::state_t              state_reg, state_next;
    logic [sdn_pkg::MAG_W-1:0]    peak_reg;
    logic [sdn_pkg::MAG_W-1:0]    rd_data_reg;
    logic [sdn_pkg::POS_W-1:0]    x_reg;
    logic [sdn_pkg::POS_W-1:0]    y_reg;
    logic [sdn_pkg::PIX_W-1:0]    pix_reg, pix_next;
    logic                         grid_reg, grid_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sdn_pkg::PIX_W-1:0]    pixel_reg;

    // frame store
    logic [sdn_pkg::MAG_W-1:0]    store_mem [DEPTH];

    logic [sdn_pkg::SIZE_W-1:0]   w, h;
    logic [sdn_pkg::POS_W-1:0]    hw, hh;
    logic                         in_accept;
    logic                         in_frame;
    logic [sdn_pkg::SIZE_W-1:0]   sx_sum, sy_sum, sx, sy;
    logic [AW-1:0]                mem_addr;
    logic                         mem_we, mem_re;
    logic                         out_load, out_free;
    logic                         grid_hit;
    logic                         pix_zero, pix_sat;
    logic                         div_start;
    logic [sdn_pkg::NUM_W-1:0]    dividend;
    sdn_pkg::div_result_t         div_res;
    logic [sdn_pkg::MAG_W:0]      rem_x2;
    logic                         round_up;
    logic [sdn_pkg::PIX_W:0]      rounded_sum;
    logic [sdn_pkg::PIX_W-1:0]    rounded;

    assign w  = eff_size(frame_width_reg, MAX_WIDTH);
    assign h  = eff_size(frame_height_reg, MAX_HEIGHT);
    assign hw = w[sdn_pkg::SIZE_W-1:1];
    assign hh = h[sdn_pkg::SIZE_W-1:1];

    assign in_stall  = (state_reg != sdn_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_frame  = ({1'b0, pos_x} < w) && ({1'b0, pos_y} < h);

    // quadrant swap: source is destination plus half the frame, wrapped
    assign sx_sum = {1'b0, pos_x} + {1'b0, hw};
    assign sy_sum = {1'b0, pos_y} + {1'b0, hh};
    assign sx     = (sx_sum >= w) ? (sx_sum - w) : sx_sum;
    assign sy     = (sy_sum >= h) ? (sy_sum - h) : sy_sum;

    // one port: a load writes its own position, a read fetches the swapped source
    assign mem_we   = in_accept && (opcode == sdn_pkg::OP_LOAD) && in_frame;
    assign mem_re   = in_accept && (opcode == sdn_pkg::OP_READ) && in_frame;
    assign mem_addr = (opcode == sdn_pkg::OP_LOAD) ?
                      store_addr({1'b0, pos_x}, {1'b0, pos_y}) : store_addr(sx, sy);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= magnitude;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sdn_pkg::SIZE_RESET;
            frame_height_reg <= sdn_pkg::SIZE_RESET;
            grid_enable_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sdn_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                sdn_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                sdn_pkg::CFG_GRID_ENABLE:  grid_enable_reg  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // running peak leaves out dc; loading dc starts a new frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else if (mem_we)
        begin
            if (pos_x == '0 && pos_y == '0)
            begin
                peak_reg <= '0;
            end
            else if (magnitude > peak_reg)
            begin
                peak_reg <= magnitude;
            end
        end
    end

    // destination kept for the grid test
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
        end
    end

    // grid lines centred on the frame
    assign grid_hit = grid_enable_reg &&
                      ((grid_mod(x_reg) == grid_mod(hw)) || (grid_mod(y_reg) == grid_mod(hh)));

    // shortcuts: a zero peak or 2v <= peak gives 0, v >= peak saturates at 255
    assign pix_zero = (peak_reg == '0) || ({rd_data_reg, 1'b0} <= {1'b0, peak_reg});
    assign pix_sat  = (rd_data_reg >= peak_reg);

    // 255*v as a shift and subtract
    assign dividend = {rd_data_reg, {sdn_pkg::QUOT_W{1'b0}}} -
                      {{sdn_pkg::QUOT_W{1'b0}}, rd_data_reg};

    sdn_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (peak_reg),
        .result   (div_res)
    );

    // round half to even on the remainder
    assign rem_x2      = {div_res.remainder, 1'b0};
    assign round_up    = (rem_x2 > {1'b0, peak_reg}) ||
                         ((rem_x2 == {1'b0, peak_reg}) && div_res.quotient[0]);
    assign rounded_sum = {1'b0, div_res.quotient} + {{sdn_pkg::PIX_W{1'b0}}, round_up};
    assign rounded     = rounded_sum[sdn_pkg::PIX_W] ? sdn_pkg::PIX_MAX :
                         rounded_sum[sdn_pkg::PIX_W-1:0];

    // output register frees the datapath while a result waits
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        pix_next   = pix_reg;
        grid_next  = grid_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sdn_pkg::ST_IDLE:
            begin
                if (in_accept && (opcode == sdn_pkg::OP_READ))
                begin
                    if (in_frame)
                    begin
                        state_next = sdn_pkg::ST_FETCH;
                    end
                    else
                    begin
                        // outside the frame: black, no grid
                        pix_next   = '0;
                        grid_next  = 1'b0;
                        state_next = sdn_pkg::ST_WRITE;
                    end
                end
            end
            sdn_pkg::ST_FETCH:
            begin
                grid_next = grid_hit;
                if (pix_zero)
                begin
                    pix_next   = '0;
                    state_next = sdn_pkg::ST_WRITE;
                end
                else if (pix_sat)
                begin
                    pix_next   = sdn_pkg::PIX_MAX;
                    state_next = sdn_pkg::ST_WRITE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = sdn_pkg::ST_DIVIDE;
                end
            end
            sdn_pkg::ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    pix_next   = rounded;
                    state_next = sdn_pkg::ST_WRITE;
                end
            end
            sdn_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = sdn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdn_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        grid_reg <= grid_next;
        if (out_load)
        begin
            pixel_reg <= grid_reg ? sdn_pkg::PIX_MAX : pix_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

endmodule

[rtl/sdn_divider.sv]
// restoring divider, one quotient bit per cycle, msb first
module sdn_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sdn_pkg::NUM_W-1:0]  dividend,
    input  logic [sdn_pkg::MAG_W-1:0]  divisor,
    output sdn_pkg::div_result_t       result
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [sdn_pkg::CNT_W-1:0]     cnt_reg;
    logic [sdn_pkg::NUM_W-1:0]     rem_reg;
    logic [sdn_pkg::NUM_W-1:0]     dsh_reg;
    logic [sdn_pkg::QUOT_W-1:0]    quo_reg;
    logic                          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= sdn_pkg::CNT_W'(sdn_pkg::QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {1'b0, divisor, {(sdn_pkg::QUOT_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[sdn_pkg::QUOT_W-2:0], ge};
        end
    end

    // final remainder is below the divisor
    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg[sdn_pkg::MAG_W-1:0];

endmodule
